// ===== sv/mm3_pkg.sv =====
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants for the MurmurHash3 x86_32 stream hash
// Holds the mixing and finalizer constants, the sequencer state encoding and
// the control structures that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;
	localparam int unsigned ROT_K = 15;
	localparam int unsigned ROT_H = 13;

	localparam logic [2:0] FULL_BYTES = 3'd4;

	// One-hot sequencer states.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MIX2 = 7'b0000010,
		ST_MIX3 = 7'b0000100,
		ST_MIX4 = 7'b0001000,
		ST_FIN0 = 7'b0010000,
		ST_FIN1 = 7'b0100000,
		ST_FIN2 = 7'b1000000
	} state_t;

	// Operand selection for the shared multiplier.
	typedef enum logic [1:0] {
		MS_KEY = 2'd0,
		MS_C2  = 2'd1,
		MS_M1  = 2'd2,
		MS_M2  = 2'd3
	} mul_sel_t;

	// Facts about the accepted item that steer the sequence.
	typedef struct packed {
		logic last;
		logic full;
		logic empty;
	} item_t;

	// Strobes from the sequencer to the datapath.
	typedef struct packed {
		logic     ready;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     h_mix;
		logic     h_fold;
		logic     fin_out;
	} ctrl_t;

endpackage

// ===== sv/mm3_mul.sv =====
// ----------------------------------------------------------------------------
// mm3_mul: shared 32-bit multiplier with registered product
// Keeps the low 32 bits of the product of the selected operands.
// ----------------------------------------------------------------------------
module mm3_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p_q
);

	logic [31:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod;
		end
	end

endmodule

// ===== sv/mm3_fsm.sv =====
// ----------------------------------------------------------------------------
// mm3_fsm: sequencer for the word mix and the finalizer
// Steps one item through the shared multiplier and the hash update strobes.
// ----------------------------------------------------------------------------
module mm3_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  mm3_pkg::item_t item,
	input  logic          out_free,
	output mm3_pkg::ctrl_t ctrl
);

	mm3_pkg::state_t state_q, state_nxt;
	logic last_q, full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm3_pkg::ST_IDLE;
			last_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q <= item.last;
				full_q <= item.full;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		ctrl.ready   = 1'b0;
		ctrl.mul_en  = 1'b0;
		ctrl.mul_sel = mm3_pkg::MS_KEY;
		ctrl.h_mix   = 1'b0;
		ctrl.h_fold  = 1'b0;
		ctrl.fin_out = 1'b0;
		case (state_q)
			mm3_pkg::ST_IDLE: begin
				ctrl.ready = 1'b1;
				if (accept) begin
					// The first multiply is issued on the accepted word itself.
					ctrl.mul_en = ~item.empty;
					state_nxt   = item.empty ? mm3_pkg::ST_FIN0 : mm3_pkg::ST_MIX2;
				end
			end
			mm3_pkg::ST_MIX2: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = mm3_pkg::MS_C2;
				state_nxt    = mm3_pkg::ST_MIX3;
			end
			mm3_pkg::ST_MIX3: begin
				ctrl.h_mix = 1'b1;
				state_nxt  = full_q ? mm3_pkg::ST_MIX4 : mm3_pkg::ST_FIN0;
			end
			mm3_pkg::ST_MIX4: begin
				ctrl.h_fold = 1'b1;
				state_nxt   = last_q ? mm3_pkg::ST_FIN0 : mm3_pkg::ST_IDLE;
			end
			mm3_pkg::ST_FIN0: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = mm3_pkg::MS_M1;
				state_nxt    = mm3_pkg::ST_FIN1;
			end
			mm3_pkg::ST_FIN1: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = mm3_pkg::MS_M2;
				state_nxt    = mm3_pkg::ST_FIN2;
			end
			mm3_pkg::ST_FIN2: begin
				if (out_free) begin
					ctrl.fin_out = 1'b1;
					state_nxt    = mm3_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mm3_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/murmur3_32_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash: MurmurHash3 x86_32 over a stream of 32-bit words
// Hashes one message per run of items, giving one hash after the last item.
// ----------------------------------------------------------------------------
// A word that is not last holds the block for two passes through the one shared
// 32-bit multiplier and two hash update steps; no new word is taken meanwhile.
// A last word then runs FIN0 and FIN1 and waits in FIN2 for the output register
// to be free before tvalid rises; a tail skips the fold, an empty word the mix.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the output
// register and marks the next item as the start of a new message.
module murmur3_32_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], seed[66:35]
	input  logic        s_axis_tlast,  // last_word
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // hash[31:0]
);

	// Unpacked input fields.
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic [31:0] seed;

	assign data_word  = s_axis_tdata[31:0];
	assign byte_count = s_axis_tdata[34:32];
	assign seed       = s_axis_tdata[66:35];

	// Running state of the message.
	logic [31:0] h_q;
	logic [31:0] len_q;
	logic        start_q;
	logic [31:0] hash_q;
	logic        m_valid_q;

	// Whether the current word is mixed as a full word.
	logic        item_full_q;

	mm3_pkg::ctrl_t ctrl;
	mm3_pkg::item_t item;
	logic           accept;
	logic           out_free;

	// Effective byte count: words that are not last always count as four,
	// and a count above four on the last word saturates to four.
	logic [2:0]  cnt_eff;
	logic [31:0] key_mask;
	logic [31:0] key_word;

	assign accept   = s_axis_tvalid & s_axis_tready;
	assign out_free = ~m_valid_q | m_axis_tready;

	always_comb begin
		if (!s_axis_tlast || byte_count > mm3_pkg::FULL_BYTES) begin
			cnt_eff = mm3_pkg::FULL_BYTES;
		end else begin
			cnt_eff = byte_count;
		end
		case (cnt_eff)
			3'd0:    key_mask = 32'h0000_0000;
			3'd1:    key_mask = 32'h0000_00ff;
			3'd2:    key_mask = 32'h0000_ffff;
			3'd3:    key_mask = 32'h00ff_ffff;
			default: key_mask = 32'hffff_ffff;
		endcase
	end

	// Bytes beyond the count on the last word are dropped before mixing.
	assign key_word = data_word & key_mask;

	assign item.last  = s_axis_tlast;
	assign item.full  = (cnt_eff == mm3_pkg::FULL_BYTES);
	assign item.empty = (cnt_eff == 3'd0);

	mm3_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	assign s_axis_tready = ctrl.ready;

	// Operand selection for the shared multiplier. The key scramble uses it
	// twice (by C1, then by C2 after a rotate) and the finalizer twice.
	logic [31:0] p_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] fin_x;

	assign fin_x = h_q ^ len_q;

	always_comb begin
		case (ctrl.mul_sel)
			mm3_pkg::MS_KEY: begin
				mul_a = key_word;
				mul_b = mm3_pkg::MIX_C1;
			end
			mm3_pkg::MS_C2: begin
				mul_a = {p_q[31-mm3_pkg::ROT_K:0], p_q[31:32-mm3_pkg::ROT_K]};
				mul_b = mm3_pkg::MIX_C2;
			end
			mm3_pkg::MS_M1: begin
				mul_a = fin_x ^ (fin_x >> 16);
				mul_b = mm3_pkg::FIN_M1;
			end
			mm3_pkg::MS_M2: begin
				mul_a = p_q ^ (p_q >> 13);
				mul_b = mm3_pkg::FIN_M2;
			end
			default: begin
				mul_a = key_word;
				mul_b = mm3_pkg::MIX_C1;
			end
		endcase
	end

	mm3_mul u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// Hash update. A full word XORs in the scrambled key and rotates; the
	// following step multiplies by five (shift and add) and adds the constant.
	// Tail bytes only XOR in the scrambled key.
	logic [31:0] h_xor;
	logic [31:0] h_next;

	assign h_xor = h_q ^ p_q;

	always_comb begin
		h_next = h_q;
		if (accept && start_q) begin
			h_next = seed;
		end else if (ctrl.h_mix) begin
			if (item_full_q) begin
				h_next = {h_xor[31-mm3_pkg::ROT_H:0], h_xor[31:32-mm3_pkg::ROT_H]};
			end else begin
				h_next = h_xor;
			end
		end else if (ctrl.h_fold) begin
			h_next = {h_q[29:0], 2'b00} + h_q + mm3_pkg::MIX_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= '0;
			len_q       <= '0;
			start_q     <= 1'b1;
			item_full_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			h_q <= h_next;
			if (accept) begin
				item_full_q <= item.full;
				// The byte total restarts with each message and wraps at 2^32.
				len_q <= (start_q ? 32'd0 : len_q) + {29'd0, cnt_eff};
				start_q <= 1'b0;
			end
			if (ctrl.fin_out) begin
				start_q   <= 1'b1;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// The finished hash waits here until taken.
	always_ff @(posedge clk) begin
		if (ctrl.fin_out) begin
			hash_q <= p_q ^ (p_q >> 16);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = hash_q;

endmodule

// ===== sv/mm3_chk.sv =====
// ----------------------------------------------------------------------------
// mm3_chk: port-level checks for the stream hash
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module mm3_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A result that is not taken keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while busy");

	// A word that is not last never produces a result right away.
	a_no_result_mid: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
		else $error("result after a word that is not last");

	// A new result only appears after the block has been busy finishing it.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result without preceding work");

endmodule

bind murmur3_32_stream_hash mm3_chk u_mm3_chk (.*);

// ===== sim/murmur3_32_stream_hash_tb.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash_tb: self-checking bench for the streaming MurmurHash3
// Feeds messages as runs of 32-bit words: first a handful of hand-picked
// corner cases, then random messages of mixed length. A behavioral model of
// MurmurHash3 x86_32 tracks every accepted word and queues the hash each
// message should produce. Each hash that leaves the block is compared with
// that queue, while random gaps and back-pressure exercise the handshakes.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash_tb;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_ITEMS = 120;    // the tail of the run has no idling
	localparam int DRAIN_CYCLES = 16;   // comfortably past the longest latency
	localparam int STALL_LIMIT = 1000;  // cycles without any handshake

	// Hash constants, kept separate from the package so a typo there shows up.
	localparam logic [31:0] KEY_MUL_A = 32'hcc9e2d51;
	localparam logic [31:0] KEY_MUL_B = 32'h1b873593;
	localparam logic [31:0] FOLD_ADD = 32'he6546b64;
	localparam logic [31:0] AVAL_MUL_A = 32'h85ebca6b;
	localparam logic [31:0] AVAL_MUL_B = 32'hc2b2ae35;
	localparam logic [2:0] WORD_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] seed;
		logic        last;
		logic [2:0]  count;
		logic [31:0] word;
	} msg_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	msg_word_t   pending_words[$];
	logic [31:0] hash_due[$];

	// Running state of the behavioral hash.
	logic [31:0] run_hash = '0;
	logic [31:0] byte_total = '0;
	logic        msg_fresh = 1'b1;

	int unsigned words_sent = 0;
	int unsigned words_taken = 0;
	int unsigned hashes_checked = 0;
	int unsigned empty_tails = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;

	murmur3_32_stream_hash dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] key_scramble(input logic [31:0] k);
		k = k * KEY_MUL_A;
		k = rot_left(k, 15);
		return k * KEY_MUL_B;
	endfunction

	function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w);
		h = h ^ key_scramble(w);
		h = rot_left(h, 13);
		return h * 32'd5 + FOLD_ADD;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * AVAL_MUL_A;
		h = h ^ (h >> 13);
		h = h * AVAL_MUL_B;
		return h ^ (h >> 16);
	endfunction

	// Advances the behavioral hash by one accepted word and queues the
	// finished hash when the word closes its message.
	task automatic absorb_word(input msg_word_t mw);
		logic [31:0] h;
		logic [2:0]  n;
		logic [31:0] keep;
		if (msg_fresh) begin
			run_hash = mw.seed;
			byte_total = '0;
			msg_fresh = 1'b0;
		end
		h = run_hash;
		if (!mw.last) begin
			// Words inside a message always carry four bytes.
			run_hash = fold_word(h, mw.word);
			byte_total = byte_total + 32'd4;
		end else begin
			n = (mw.count > WORD_BYTES) ? WORD_BYTES : mw.count;
			if (n == WORD_BYTES) begin
				h = fold_word(h, mw.word);
			end else if (n != 3'd0) begin
				// Tail bytes are scrambled and XORed in, without the fold step.
				keep = (32'd1 << (8 * n)) - 32'd1;
				h = h ^ key_scramble(mw.word & keep);
			end else begin
				empty_tails++;
			end
			byte_total = byte_total + 32'(n);
			hash_due.push_back(avalanche(h ^ byte_total));
			run_hash = '0;
			byte_total = '0;
			msg_fresh = 1'b1;
		end
	endtask

	function automatic void push_word(input logic [31:0] w, input logic [2:0] c,
		input logic l, input logic [31:0] s);
		msg_word_t mw;
		mw.word = w;
		mw.count = c;
		mw.last = l;
		mw.seed = s;
		pending_words.push_back(mw);
	endfunction

	// Random data with the all-zero and all-one words showing up now and then.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	// Driver: offers the next queued word once the current one is taken,
	// with occasional bursts of idle cycles between words.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || words_taken == words_sent)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				s_axis_tdata <= {5'b0, pending_words[0].seed, pending_words[0].count,
					pending_words[0].word};
				s_axis_tlast <= pending_words[0].last;
				s_axis_tvalid <= 1'b1;
				void'(pending_words.pop_front());
				words_sent <= words_sent + 1;
				if (pending_words.size() > CALM_ITEMS && $urandom_range(0, 4) == 0)
					send_gap <= $urandom_range(1, 6);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side: ready drops for random bursts, except in the calm tail.
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (pending_words.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
					recv_stall <= $urandom_range(1, 6);
			end
		end
	end

	// Monitor: predicts on every accepted word, checks every accepted hash
	// and ends the run if the handshakes stop moving.
	always @(posedge clk) begin : monitor
		logic in_hs;
		logic out_hs;
		logic [31:0] want;
		if (arst_n) begin
			in_hs = s_axis_tvalid && s_axis_tready;
			out_hs = m_axis_tvalid && m_axis_tready;
			if (in_hs) begin
				absorb_word({s_axis_tdata[66:35], s_axis_tlast, s_axis_tdata[34:32],
					s_axis_tdata[31:0]});
				words_taken++;
			end
			if (out_hs) begin
				if (hash_due.size() == 0) begin
					$error("hash: expected none, actual 0x%08h", m_axis_tdata);
					errors++;
				end else begin
					want = hash_due.pop_front();
					hashes_checked++;
					if (m_axis_tdata !== want) begin
						$error("hash: expected 0x%08h, actual 0x%08h", want, m_axis_tdata);
						errors++;
					end
				end
			end
			if (in_hs || out_hs)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("murmur3_32_stream_hash_tb failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_words;
		logic [31:0] msg_seed;
		logic [2:0] c;

		// Directed corner cases. Single-word messages cover byte counts 0 to 5 and 7
		// on a last word, including the saturating values above four, with
		// junk in the unused bytes and seeds at both extremes.
		push_word(32'hffffffff, 3'd0, 1'b1, 32'h00000000);
		push_word(32'hffffffff, 3'd0, 1'b1, 32'hffffffff);
		push_word(32'hffffffff, 3'd1, 1'b1, 32'h00000000);
		push_word(32'ha5a5a5a5, 3'd2, 1'b1, 32'h9747b28c);
		push_word(32'hffffffff, 3'd3, 1'b1, 32'hffffffff);
		push_word(32'hffffffff, 3'd4, 1'b1, 32'h00000000);
		push_word(32'h12345678, 3'd5, 1'b1, 32'h00000001);
		push_word(32'h00000000, 3'd7, 1'b1, 32'hffffffff);
		// Inner words ignore their byte count and later seeds.
		push_word(32'hffffffff, 3'd0, 1'b0, 32'h00000000);
		push_word(32'h00000000, 3'd7, 1'b0, 32'hffffffff);
		push_word(32'hffffffff, 3'd3, 1'b1, 32'h00000000);
		// A full word followed by an empty last word, then longer messages ending in a full and a one-byte last word.
		push_word(32'hdeadbeef, 3'd4, 1'b0, 32'h0000002a);
		push_word(32'h0badf00d, 3'd0, 1'b1, 32'h55555555);
		push_word(32'h01020304, 3'd2, 1'b0, 32'h80000000);
		push_word(32'h05060708, 3'd4, 1'b0, 32'h7fffffff);
		push_word(32'h090a0b0c, 3'd4, 1'b1, 32'h00000000);
		push_word(32'h80000001, 3'd6, 1'b0, 32'haaaaaaaa);
		push_word(32'h7ffffffe, 3'd1, 1'b1, 32'h00000000);

		// Random messages, mostly short, with the odd long one.
		while (pending_words.size() < RANDOM_ITEMS + 18) begin
			n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
				: $urandom_range(1, 6);
			msg_seed = pick_value();
			for (int i = 0; i < n_words; i++) begin
				if (i == n_words - 1)
					c = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 4))
						: 3'($urandom_range(0, 7));
				else
					c = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : WORD_BYTES;
				push_word(pick_value(), c, i == n_words - 1, (i == 0) ? msg_seed : $urandom);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (pending_words.size() != 0 || words_taken != words_sent
			|| hash_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("hashed %0d messages from %0d words, %0d of them closing with no tail bytes",
			hashes_checked, words_taken, empty_tails);
		$display("last-word byte counts 0 to 7, ignored inner counts and seeds, both stalls");
		if (errors == 0)
			$display("murmur3_32_stream_hash_tb passed");
		else
			$display("murmur3_32_stream_hash_tb failed");
		$finish;
	end

endmodule
